/* design/running_median_queue_defines.svh */
// Assertion macros shared by the running median queue checkers.
// Depends on clk and arst_n being visible where a macro is used.
`ifndef RUNNING_MEDIAN_QUEUE_DEFINES_SVH
`define RUNNING_MEDIAN_QUEUE_DEFINES_SVH

// hold b in the same cycle as a
`define RMQ_IMPLY(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("rmq check failed");

// hold b in the cycle after a
`define RMQ_IMPLY_NEXT(label, a, b) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("rmq check failed");

`endif

/* design/rmq_pkg.sv */
// Types and codes for the running median queue.
// No dependencies; used by the controller, datapath, top level and checker.
package rmq_pkg;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_TAKE   = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic               op;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] median;
		logic [1:0]         status;
		logic [10:0]        count_after;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECIDE, S_INS_CHECK, S_INS_CMP,
		S_TAKE_READ, S_TAKE_GRAB, S_SHIFT_CHECK, S_SHIFT_WR, S_FINISH
	} state_t;

	typedef enum logic [3:0] {
		DP_NOP, DP_LOAD, DP_INS_READ, DP_INS_MOVE, DP_INS_PLACE,
		DP_TAKE_READ, DP_TAKE_GRAB, DP_SHIFT_READ, DP_SHIFT_WRITE,
		DP_TAKE_DONE, DP_EMIT
	} dp_cmd_t;

	typedef struct packed {
		logic is_take;
		logic refused;
		logic ins_bottom;
		logic ins_bigger;
		logic shift_done;
		logic out_free;
	} dp_stat_t;

endpackage

/* design/rmq_ctrl.sv */
// Request sequencer for the running median queue.
// Depends on rmq_pkg; drives the datapath commands.
module rmq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  rmq_pkg::dp_stat_t stat,
	output rmq_pkg::dp_cmd_t  cmd
);
	import rmq_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (req_valid) state_d = S_DECIDE;
			end
			S_DECIDE: begin
				if (stat.refused)      state_d = S_FINISH;
				else if (stat.is_take) state_d = S_TAKE_READ;
				else                   state_d = S_INS_CHECK;
			end
			S_INS_CHECK: begin
				state_d = stat.ins_bottom ? S_FINISH : S_INS_CMP;
			end
			S_INS_CMP: begin
				state_d = stat.ins_bigger ? S_INS_CHECK : S_FINISH;
			end
			S_TAKE_READ:   state_d = S_TAKE_GRAB;
			S_TAKE_GRAB:   state_d = S_SHIFT_CHECK;
			S_SHIFT_CHECK: begin
				state_d = stat.shift_done ? S_FINISH : S_SHIFT_WR;
			end
			S_SHIFT_WR:    state_d = S_SHIFT_CHECK;
			S_FINISH: begin
				if (stat.out_free) state_d = S_IDLE;
			end
			default:       state_d = S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		cmd       = DP_NOP;
		unique case (state_q)
			S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) cmd = DP_LOAD;
			end
			S_DECIDE:      cmd = DP_NOP;
			S_INS_CHECK:   cmd = stat.ins_bottom ? DP_INS_PLACE : DP_INS_READ;
			S_INS_CMP:     cmd = stat.ins_bigger ? DP_INS_MOVE : DP_INS_PLACE;
			S_TAKE_READ:   cmd = DP_TAKE_READ;
			S_TAKE_GRAB:   cmd = DP_TAKE_GRAB;
			S_SHIFT_CHECK: cmd = stat.shift_done ? DP_TAKE_DONE : DP_SHIFT_READ;
			S_SHIFT_WR:    cmd = DP_SHIFT_WRITE;
			S_FINISH:      cmd = stat.out_free ? DP_EMIT : DP_NOP;
			default:       cmd = DP_NOP;
		endcase
	end

endmodule

/* design/rmq_dp.sv */
// Datapath of the running median queue: sorted value memory, count, index and result register.
// Depends on rmq_pkg; commanded by rmq_ctrl.
module rmq_dp #(
	parameter int CAPACITY = 1024
) (
	input  logic              clk,
	input  logic              arst_n,
	input  rmq_pkg::req_t     req,
	input  rmq_pkg::dp_cmd_t  cmd,
	output rmq_pkg::dp_stat_t stat,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rmq_pkg::rsp_t     rsp
);
	import rmq_pkg::*;

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [31:0]   mem_q [CAPACITY];
	logic [31:0]   rd_q;
	logic [31:0]   val_q;
	logic [31:0]   med_q;
	logic [1:0]    status_q;
	logic          op_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] idx_q;
	logic          out_valid_q;
	rsp_t          rsp_q;

	logic [CW-1:0] idx_m1;
	logic [CW:0]   idx_p1;
	logic [CW-1:0] rank;
	logic [AW-1:0] rd_addr;
	logic [31:0]   wr_data;
	logic          wr_en;
	logic          full;
	logic          empty;

	assign idx_m1 = idx_q - CW'(1);
	assign idx_p1 = {1'b0, idx_q} + (CW + 1)'(1);
	assign rank   = (cnt_q - CW'(1)) >> 1;
	assign full   = (cnt_q == CW'(CAPACITY));
	assign empty  = (cnt_q == '0);

	always_comb begin
		case (cmd)
			DP_INS_READ:  rd_addr = idx_m1[AW-1:0];
			DP_TAKE_READ: rd_addr = rank[AW-1:0];
			default:      rd_addr = idx_p1[AW-1:0];
		endcase
		wr_en   = (cmd == DP_INS_MOVE) || (cmd == DP_INS_PLACE) || (cmd == DP_SHIFT_WRITE);
		wr_data = (cmd == DP_INS_PLACE) ? val_q : rd_q;
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[idx_q[AW-1:0]] <= wr_data;
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		unique case (cmd)
			DP_LOAD: begin
				val_q <= req.value;
				med_q <= '0;
				if (req.op == OP_INSERT) status_q <= full ? ST_FULL : ST_OK;
				else                     status_q <= empty ? ST_EMPTY : ST_OK;
			end
			DP_TAKE_GRAB: med_q <= rd_q;
			default: ;
		endcase
		if (cmd == DP_EMIT) begin
			rsp_q.median      <= med_q;
			rsp_q.status      <= status_q;
			rsp_q.count_after <= 11'(cnt_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			idx_q       <= '0;
			op_q        <= OP_INSERT;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd)
				DP_LOAD: begin
					op_q  <= req.op;
					idx_q <= cnt_q;
				end
				DP_INS_MOVE:    idx_q <= idx_m1;
				DP_INS_PLACE:   cnt_q <= cnt_q + CW'(1);
				DP_TAKE_READ:   idx_q <= rank;
				DP_SHIFT_WRITE: idx_q <= idx_p1[CW-1:0];
				DP_TAKE_DONE:   cnt_q <= cnt_q - CW'(1);
				default: ;
			endcase
			if (cmd == DP_EMIT)     out_valid_q <= 1'b1;
			else if (rsp_ready)     out_valid_q <= 1'b0;
		end
	end

	assign stat.is_take    = (op_q == OP_TAKE);
	assign stat.refused    = (status_q != ST_OK);
	assign stat.ins_bottom = (idx_q == '0);
	assign stat.ins_bigger = ($signed(rd_q) > $signed(val_q));
	assign stat.shift_done = (idx_p1 >= {1'b0, cnt_q});
	assign stat.out_free   = !out_valid_q || rsp_ready;

	assign rsp_valid = out_valid_q;
	assign rsp       = rsp_q;

endmodule

/* design/running_median_queue.sv */
// Running median queue top level: sequencer plus datapath.
// Depends on rmq_pkg, rmq_ctrl and rmq_dp.
// Holds up to CAPACITY signed values in ascending order in a memory with one read and one
// write port and answers one result per request. An insert moves the k held values above the
// new one up by one entry each, and a take moves those above the median down; the memory
// moves one entry at a time (read, then write). One request is in work at a time; a finished
// result waits in the output register while the next is taken.
// No clearing pass follows reset.
module running_median_queue #(
	parameter int CAPACITY = 1024
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  rmq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output rmq_pkg::rsp_t rsp
);
	import rmq_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	rmq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	rmq_dp #(.CAPACITY(CAPACITY)) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

/* design/rmq_checker.sv */
// Port-level checks for the running median queue, bound to the top level.
// Depends on rmq_pkg and running_median_queue_defines.svh.
`include "running_median_queue_defines.svh"

module rmq_checker #(
	parameter int CAPACITY = 1024
) (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_ready,
	input rmq_pkg::req_t req,
	input logic          rsp_valid,
	input logic          rsp_ready,
	input rmq_pkg::rsp_t rsp
);
	import rmq_pkg::*;

	`RMQ_IMPLY(a_refused_zero, rsp_valid && rsp.status != ST_OK, rsp.median == '0)
	`RMQ_IMPLY(a_status_code, rsp_valid, rsp.status != 2'd3)
	`RMQ_IMPLY(a_empty_count, rsp_valid && rsp.status == ST_EMPTY, rsp.count_after == '0)
	`RMQ_IMPLY(a_full_count, rsp_valid && rsp.status == ST_FULL, rsp.count_after == 11'(CAPACITY))
	`RMQ_IMPLY_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready)

endmodule

bind running_median_queue rmq_checker #(.CAPACITY(CAPACITY)) u_rmq_checker (.*);
